// ----- rtl/sqv_pkg.sv -----
`default_nettype none

package sqv_pkg;

  // Item codes.
  localparam logic [2:0] ACT_WRITE   = 3'd0;
  localparam logic [2:0] ACT_ENABLE  = 3'd1;
  localparam logic [2:0] ACT_TICK    = 3'd2;
  localparam logic [2:0] ACT_QUARTER = 3'd3;
  localparam logic [2:0] ACT_HALF    = 3'd4;

  // Register select codes.
  localparam logic [1:0] REG_DUTY    = 2'd0;
  localparam logic [1:0] REG_SWEEP   = 2'd1;
  localparam logic [1:0] REG_PER_LO  = 2'd2;
  localparam logic [1:0] REG_PER_HI  = 2'd3;

  localparam int unsigned PeriodW = 11;
  localparam int unsigned TimerW  = 12;
  localparam logic [PeriodW-1:0] PERIOD_LIMIT = 11'h7FF;
  localparam logic [3:0] ENV_MAX = 4'd15;

  // Length counter load values, indexed by bits 7:3 of the written byte.
  localparam logic [7:0] LENGTH_LUT [32] = '{
    8'd10, 8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,  8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12, 8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  // Duty waveforms; bit n is the output at sequence step n.
  localparam logic [7:0] DUTY_LUT [4] = '{
    8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
  };

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] reg_select;
    logic [7:0] write_value;
    logic       enable_bit;
  } sqv_item_t;

  // Sweep target as a 13-bit two's complement value. Bit 12 set means the
  // target went below zero; bit 11 set with bit 12 clear means it overflowed.
  function automatic logic [12:0] sweep_target(input logic [PeriodW-1:0] period,
                                               input logic [2:0] amount,
                                               input logic negate,
                                               input logic ones_comp);
    logic [12:0] p;
    logic [12:0] change;
    p      = {2'b00, period};
    change = {2'b00, period >> amount};
    if (negate) begin
      sweep_target = p - change - {12'd0, ones_comp};
    end else begin
      sweep_target = p + change;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sqv_in_stage.sv -----
`default_nettype none

module sqv_in_stage
  import sqv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire sqv_item_t item_i,
  input  wire logic      advance_i,
  output logic           stage_valid_o,
  output sqv_item_t      stage_item_o
);

  logic      valid_q, valid_d;
  sqv_item_t item_q;
  logic      fire;

  // The stage can take a transaction if empty or if emptying in this cycle.
  assign in_ready_o = !valid_q || advance_i;
  assign fire       = in_valid_i && in_ready_o;
  assign valid_d    = fire || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= item_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_item_o  = item_q;

endmodule

`default_nettype wire

// ----- rtl/sqv_voice.sv -----
`default_nettype none

module sqv_voice
  import sqv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      ones_comp_i,
  input  wire logic      advance_i,
  input  wire sqv_item_t item_i,
  output logic [3:0]     level_d_o,
  output logic           active_d_o
);

  logic [1:0]         duty_q, duty_d;
  logic               halt_q, halt_d;
  logic               constvol_q, constvol_d;
  logic [3:0]         vol_q, vol_d;
  logic               swp_on_q, swp_on_d;
  logic [2:0]         swp_per_q, swp_per_d;
  logic               swp_neg_q, swp_neg_d;
  logic [2:0]         swp_amt_q, swp_amt_d;
  logic               swp_rld_q, swp_rld_d;
  logic [2:0]         swp_div_q, swp_div_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [TimerW-1:0]  tcount_q, tcount_d;
  logic [2:0]         step_q, step_d;
  logic [7:0]         length_q, length_d;
  logic               enabled_q, enabled_d;
  logic [3:0]         env_div_q, env_div_d;
  logic [3:0]         env_lvl_q, env_lvl_d;
  logic               env_rst_q, env_rst_d;
  logic [3:0]         level_q, level_d;

  logic [12:0]       old_target;
  logic [12:0]       new_target;
  logic [TimerW-1:0] tcount_dec;
  logic              mute;

  assign old_target = sweep_target(period_q, swp_amt_q, swp_neg_q, ones_comp_i);
  assign new_target = sweep_target(period_d, swp_amt_d, swp_neg_d, ones_comp_i);
  assign tcount_dec = tcount_q - TimerW'(1);

  always_comb begin
    duty_d     = duty_q;
    halt_d     = halt_q;
    constvol_d = constvol_q;
    vol_d      = vol_q;
    swp_on_d   = swp_on_q;
    swp_per_d  = swp_per_q;
    swp_neg_d  = swp_neg_q;
    swp_amt_d  = swp_amt_q;
    swp_rld_d  = swp_rld_q;
    swp_div_d  = swp_div_q;
    period_d   = period_q;
    tcount_d   = tcount_q;
    step_d     = step_q;
    length_d   = length_q;
    enabled_d  = enabled_q;
    env_div_d  = env_div_q;
    env_lvl_d  = env_lvl_q;
    env_rst_d  = env_rst_q;

    case (item_i.action)
      ACT_WRITE: begin
        case (item_i.reg_select)
          REG_DUTY: begin
            duty_d     = item_i.write_value[7:6];
            halt_d     = item_i.write_value[5];
            constvol_d = item_i.write_value[4];
            vol_d      = item_i.write_value[3:0];
          end
          REG_SWEEP: begin
            swp_on_d  = item_i.write_value[7];
            swp_per_d = item_i.write_value[6:4];
            swp_neg_d = item_i.write_value[3];
            swp_amt_d = item_i.write_value[2:0];
            swp_rld_d = 1'b1;
          end
          REG_PER_LO: begin
            period_d = {period_q[10:8], item_i.write_value};
          end
          REG_PER_HI: begin
            if (enabled_q) begin
              length_d = LENGTH_LUT[item_i.write_value[7:3]];
            end
            period_d  = {item_i.write_value[2:0], period_q[7:0]};
            step_d    = 3'd0;
            env_rst_d = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ACT_ENABLE: begin
        enabled_d = item_i.enable_bit;
        if (!item_i.enable_bit) begin
          length_d = 8'd0;
        end
      end
      ACT_TICK: begin
        if (tcount_dec == '0) begin
          tcount_d = {1'b0, period_q} + TimerW'(1);
          step_d   = step_q + 3'd1;
        end else begin
          tcount_d = tcount_dec;
        end
      end
      ACT_QUARTER: begin
        if (env_rst_q) begin
          env_rst_d = 1'b0;
          env_lvl_d = ENV_MAX;
          env_div_d = vol_q;
        end else if (env_div_q == 4'd0) begin
          env_div_d = vol_q;
          if (env_lvl_q != 4'd0) begin
            env_lvl_d = env_lvl_q - 4'd1;
          end else if (halt_q) begin
            env_lvl_d = ENV_MAX;
          end
        end else begin
          env_div_d = env_div_q - 4'd1;
        end
      end
      ACT_HALF: begin
        if (!halt_q && (length_q != 8'd0)) begin
          length_d = length_q - 8'd1;
        end
        // The target is in range when it is neither negative nor overflowed.
        if ((swp_div_q == 3'd0) && swp_on_q && (period_q[10:3] != 8'd0) &&
            (swp_amt_q != 3'd0) && (old_target[12:11] == 2'b00)) begin
          period_d = old_target[10:0];
        end
        if (swp_rld_q || (swp_div_q == 3'd0)) begin
          swp_rld_d = 1'b0;
          swp_div_d = swp_per_q;
        end else begin
          swp_div_d = swp_div_q - 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output level from the updated state; unused codes keep the old level.
  always_comb begin
    mute = (length_d == 8'd0) || (period_d[10:3] == 8'd0) ||
           !DUTY_LUT[duty_d][step_d] ||
           (!new_target[12] && new_target[11]);
    level_d = level_q;
    if (item_i.action <= ACT_HALF) begin
      if (mute) begin
        level_d = 4'd0;
      end else if (constvol_d) begin
        level_d = vol_d;
      end else begin
        level_d = env_lvl_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q     <= '0;
      halt_q     <= 1'b0;
      constvol_q <= 1'b0;
      vol_q      <= '0;
      swp_on_q   <= 1'b0;
      swp_per_q  <= '0;
      swp_neg_q  <= 1'b0;
      swp_amt_q  <= '0;
      swp_rld_q  <= 1'b0;
      swp_div_q  <= '0;
      period_q   <= '0;
      tcount_q   <= TimerW'(1);
      step_q     <= '0;
      length_q   <= '0;
      enabled_q  <= 1'b0;
      env_div_q  <= '0;
      env_lvl_q  <= '0;
      env_rst_q  <= 1'b0;
      level_q    <= '0;
    end else if (advance_i) begin
      duty_q     <= duty_d;
      halt_q     <= halt_d;
      constvol_q <= constvol_d;
      vol_q      <= vol_d;
      swp_on_q   <= swp_on_d;
      swp_per_q  <= swp_per_d;
      swp_neg_q  <= swp_neg_d;
      swp_amt_q  <= swp_amt_d;
      swp_rld_q  <= swp_rld_d;
      swp_div_q  <= swp_div_d;
      period_q   <= period_d;
      tcount_q   <= tcount_d;
      step_q     <= step_d;
      length_q   <= length_d;
      enabled_q  <= enabled_d;
      env_div_q  <= env_div_d;
      env_lvl_q  <= env_lvl_d;
      env_rst_q  <= env_rst_d;
      level_q    <= level_d;
    end
  end

  assign level_d_o  = level_d;
  assign active_d_o = (length_d != 8'd0);

endmodule

`default_nettype wire

// ----- rtl/square_wave_voice_with_sweep.sv -----
// A transaction passes through the input stage register and then the result register.
// Throughput: one transaction per cycle, sustained, while out_ready_i is held high.
// The voice state is updated as a transaction moves into the result register.
// Reset (rst_ni low, asynchronous) clears all voice state, both pipeline valid bits,
// and the ones' complement sweep setting; the timer count resets to one.
`default_nettype none

module square_wave_voice_with_sweep
  import sqv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration: ones' complement sweep negation.
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  // Input channel.
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] action_i,
  input  wire logic [1:0] reg_select_i,
  input  wire logic [7:0] write_value_i,
  input  wire logic       enable_bit_i,
  // Result channel.
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      level_o,
  output logic            length_active_o
);

  logic      ones_comp_q;
  sqv_item_t in_item;
  sqv_item_t stage_item;
  logic      stage_valid;
  logic      advance;
  logic      out_valid_q, out_valid_d;
  logic [3:0] level_q;
  logic      active_q;
  logic [3:0] level_next;
  logic      active_next;

  assign in_item.action      = action_i;
  assign in_item.reg_select  = reg_select_i;
  assign in_item.write_value = write_value_i;
  assign in_item.enable_bit  = enable_bit_i;

  // The staged transaction is processed when the result register is free or
  // is being emptied in this same cycle. Processing commits the voice state
  // and loads the result register together, so nothing is ever repeated.
  assign advance     = stage_valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  sqv_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .item_i        (in_item),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_item_o  (stage_item)
  );

  sqv_voice u_voice (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ones_comp_i (ones_comp_q),
    .advance_i   (advance),
    .item_i      (stage_item),
    .level_d_o   (level_next),
    .active_d_o  (active_next)
  );

  // The user must write configuration only while the voice is idle; it is not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ones_comp_q <= 1'b0;
    end else if (cfg_we_i) begin
      ones_comp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload holds while a transaction waits to be taken.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      level_q  <= level_next;
      active_q <= active_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign level_o         = level_q;
  assign length_active_o = active_q;

endmodule

`default_nettype wire

// ----- tb/tb_square_wave_voice_with_sweep.sv -----
`default_nettype none

module tb_square_wave_voice_with_sweep;
  import sqv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Action codes above ACT_HALF are not decoded by the voice. They are sent as noise.
  localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
  localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;

  // Periods below this value silence the voice.
  localparam logic [PeriodW-1:0] MIN_AUDIBLE_PERIOD = 11'd8;

  // A result passes through the input stage and result registers after acceptance.
  // The drain and end waits let the pipeline settle after the last result.
  localparam int DRAIN_CYCLES      = 4;
  localparam int END_CYCLES        = 10;
  localparam int SINK_HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT       = 2000;

  typedef struct packed {
    logic [3:0] level;
    logic       length_active;
  } voice_result_t;

  // Every input of the block is held at a known value from time zero.
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [2:0] action_i      = '0;
  logic [1:0] reg_select_i  = '0;
  logic [7:0] write_value_i = '0;
  logic       enable_bit_i  = 1'b0;
  logic       out_ready_i   = 1'b0;
  wire logic  in_ready_o;
  wire logic  out_valid_o;
  wire logic [3:0] level_o;
  wire logic  length_active_o;

  square_wave_voice_with_sweep u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .reg_select_i    (reg_select_i),
    .write_value_i   (write_value_i),
    .enable_bit_i    (enable_bit_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_o         (level_o),
    .length_active_o (length_active_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the voice. The initial values are the reset state, which is
  // fine because reset is applied only once, at the start of the run.
  logic               ones_comp_sweep = 1'b0;
  logic [1:0]         v_duty          = '0;
  logic               v_halt          = 1'b0;
  logic               v_const_vol     = 1'b0;
  logic [3:0]         v_vol           = '0;
  logic               v_sweep_en      = 1'b0;
  logic [2:0]         v_sweep_per     = '0;
  logic               v_sweep_neg     = 1'b0;
  logic [2:0]         v_sweep_shift   = '0;
  logic               v_sweep_reload  = 1'b0;
  logic [2:0]         v_sweep_div     = '0;
  logic [PeriodW-1:0] v_period        = '0;
  logic [TimerW-1:0]  v_timer         = 12'd1;
  logic [2:0]         v_step          = '0;
  logic [7:0]         v_length        = '0;
  logic               v_enabled       = 1'b0;
  logic [3:0]         v_env_div       = '0;
  logic [3:0]         v_env_vol       = '0;
  logic               v_env_start     = 1'b0;
  logic [3:0]         v_level         = '0;

  // Levels predicted for accepted transactions, oldest first.
  voice_result_t pending_levels [$];

  int  mismatch_count    = 0;
  int  results_checked   = 0;
  int  accepted_total    = 0;
  int  voice_events_sent = 0;
  int  action_seen [8]   = '{default: 0};

  // Flow control shared between the stimulus and the output sink.
  logic steady_flow   = 1'b0;
  logic sink_hold_req = 1'b0;
  logic offering      = 1'b0;

  // The sweep target can go below zero when negated, so it is kept as a
  // signed integer rather than at the period width.
  function automatic int sweep_goal();
    int delta;
    delta = int'(v_period >> v_sweep_shift);
    if (v_sweep_neg) begin
      delta = -delta - (ones_comp_sweep ? 1 : 0);
    end
    return int'(v_period) + delta;
  endfunction

  function automatic logic [3:0] voice_level();
    if (v_length == '0 || v_period < MIN_AUDIBLE_PERIOD ||
        !DUTY_LUT[v_duty][v_step] || sweep_goal() > int'(PERIOD_LIMIT)) begin
      return '0;
    end
    return v_const_vol ? v_vol : v_env_vol;
  endfunction

  // Applies one accepted transaction to the shadow voice and returns the level
  // and length flag that the block must report for it.
  task automatic advance_voice(input sqv_item_t item, output voice_result_t res);
    int goal;
    case (item.action)
      ACT_WRITE: begin
        case (item.reg_select)
          REG_DUTY: begin
            v_duty      = item.write_value[7:6];
            v_halt      = item.write_value[5];
            v_const_vol = item.write_value[4];
            v_vol       = item.write_value[3:0];
          end
          REG_SWEEP: begin
            v_sweep_en     = item.write_value[7];
            v_sweep_per    = item.write_value[6:4];
            v_sweep_neg    = item.write_value[3];
            v_sweep_shift  = item.write_value[2:0];
            v_sweep_reload = 1'b1;
          end
          REG_PER_LO: begin
            v_period[7:0] = item.write_value;
          end
          REG_PER_HI: begin
            // A disabled voice ignores the length load but still takes the rest.
            if (v_enabled) begin
              v_length = LENGTH_LUT[item.write_value[7:3]];
            end
            v_period[10:8] = item.write_value[2:0];
            v_step         = '0;
            v_env_start    = 1'b1;
          end
          default: begin
          end
        endcase
        v_level = voice_level();
      end
      ACT_ENABLE: begin
        v_enabled = item.enable_bit;
        if (!item.enable_bit) begin
          v_length = '0;
        end
        v_level = voice_level();
      end
      ACT_TICK: begin
        v_timer = v_timer - 12'd1;
        if (v_timer == '0) begin
          v_timer = {1'b0, v_period} + 12'd1;
          v_step  = v_step + 3'd1;
        end
        v_level = voice_level();
      end
      ACT_QUARTER: begin
        if (v_env_start) begin
          v_env_start = 1'b0;
          v_env_vol   = ENV_MAX;
          v_env_div   = v_vol;
        end else if (v_env_div == '0) begin
          v_env_div = v_vol;
          if (v_env_vol != '0) begin
            v_env_vol = v_env_vol - 4'd1;
          end else if (v_halt) begin
            v_env_vol = ENV_MAX;
          end
        end else begin
          v_env_div = v_env_div - 4'd1;
        end
        v_level = voice_level();
      end
      ACT_HALF: begin
        if (!v_halt && v_length != '0) begin
          v_length = v_length - 8'd1;
        end
        if (v_sweep_div == '0) begin
          goal = sweep_goal();
          if (v_sweep_en && v_period >= MIN_AUDIBLE_PERIOD && v_sweep_shift != '0 &&
              goal >= 0 && goal <= int'(PERIOD_LIMIT)) begin
            v_period = goal[10:0];
          end
        end
        if (v_sweep_reload || v_sweep_div == '0) begin
          v_sweep_reload = 1'b0;
          v_sweep_div    = v_sweep_per;
        end else begin
          v_sweep_div = v_sweep_div - 3'd1;
        end
        v_level = voice_level();
      end
      default: begin
        // Unused codes leave the voice and its last level untouched.
      end
    endcase
    res.level         = v_level;
    res.length_active = (v_length != '0);
  endtask

  // Most gaps are zero or a few cycles; a small share are long.
  function automatic int rand_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end
    if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic sqv_item_t voice_event(input logic [2:0] action,
                                            input logic [1:0] sel,
                                            input logic [7:0] value,
                                            input logic       en);
    sqv_item_t item;
    item.action      = action;
    item.reg_select  = sel;
    item.write_value = value;
    item.enable_bit  = en;
    return item;
  endfunction

  // Register bytes are skewed toward short periods so that the duty sequence
  // moves and the voice is audible for a useful share of the run.
  function automatic logic [7:0] biased_value(input logic [1:0] sel);
    logic [7:0] value;
    value = 8'($urandom);
    if (sel == REG_PER_HI && $urandom_range(0, 9) < 7) begin
      value[2:0] = '0;
    end
    if (sel == REG_PER_LO && $urandom_range(0, 1) == 0) begin
      value = 8'($urandom_range(8, 48));
    end
    return value;
  endfunction

  function automatic sqv_item_t random_voice_event();
    sqv_item_t item;
    int        pick;
    item = sqv_item_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      item.action = ACT_TICK;
    end else if (pick < 60) begin
      item.action = ACT_QUARTER;
    end else if (pick < 75) begin
      item.action = ACT_HALF;
    end else if (pick < 88) begin
      item.action      = ACT_WRITE;
      item.write_value = biased_value(item.reg_select);
    end else if (pick < 94) begin
      item.action     = ACT_ENABLE;
      item.enable_bit = ($urandom_range(0, 5) != 0);
    end else begin
      item.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    end
    return item;
  endfunction

  // Drops valid at the current edge, at most once per time step.
  task automatic stop_sending();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offers one transaction and returns at the edge where it is accepted. The
  // idle gap comes first, so back-to-back transactions keep valid high.
  task automatic send_voice_event(input sqv_item_t item);
    int gap;
    gap = steady_flow ? 0 : rand_gap();
    if (gap > 0) begin
      stop_sending();
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= item.action;
    reg_select_i  <= item.reg_select;
    write_value_i <= item.write_value;
    enable_bit_i  <= item.enable_bit;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    accepted_total++;
    if (item.action <= ACT_HALF) begin
      voice_events_sent++;
    end
  endtask

  // Counts kept by this process and the checker, so a transaction accepted at
  // the current edge is never missed.
  task automatic wait_for_drain();
    while (results_checked < accepted_total) @(posedge clk_i);
  endtask

  // The sweep mode is only changed with the pipeline empty and settled.
  task automatic set_ones_comp(input logic value);
    stop_sending();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ones_comp_sweep = value;
  endtask

  // A typical program for the voice: enable it and fill all four registers.
  task automatic send_voice_preamble();
    send_voice_event(voice_event(ACT_ENABLE, 2'($urandom), 8'($urandom), 1'b1));
    send_voice_event(voice_event(ACT_WRITE, REG_DUTY, biased_value(REG_DUTY),
                                 1'($urandom)));
    send_voice_event(voice_event(ACT_WRITE, REG_SWEEP, biased_value(REG_SWEEP),
                                 1'($urandom)));
    send_voice_event(voice_event(ACT_WRITE, REG_PER_LO, biased_value(REG_PER_LO),
                                 1'($urandom)));
    send_voice_event(voice_event(ACT_WRITE, REG_PER_HI, biased_value(REG_PER_HI),
                                 1'($urandom)));
  endtask

  // Unused codes straight out of reset must report the reset level, and the
  // first tick reloads the timer from the zero period.
  task automatic test_unused_actions_after_reset();
    send_voice_event(voice_event(ACT_UNUSED_LO, REG_DUTY, 8'h00, 1'b0));
    send_voice_event(voice_event(ACT_UNUSED_MID, REG_SWEEP, 8'hA5, 1'b1));
    send_voice_event(voice_event(ACT_UNUSED_HI, REG_PER_HI, 8'hFF, 1'b1));
    send_voice_event(voice_event(ACT_TICK, REG_DUTY, 8'h00, 1'b0));
  endtask

  // Register bytes at both extremes, a length load while the voice is
  // disabled, an overflowing sweep target and a period below the audible limit.
  task automatic test_register_extremes();
    send_voice_event(voice_event(ACT_WRITE, REG_PER_HI, 8'hFF, 1'b0));
    send_voice_event(voice_event(ACT_ENABLE, REG_DUTY, 8'h00, 1'b1));
    send_voice_event(voice_event(ACT_WRITE, REG_DUTY, 8'hFF, 1'b0));
    send_voice_event(voice_event(ACT_WRITE, REG_PER_LO, 8'hFF, 1'b0));
    send_voice_event(voice_event(ACT_WRITE, REG_PER_HI, 8'hFF, 1'b1));
    send_voice_event(voice_event(ACT_WRITE, REG_SWEEP, 8'hFF, 1'b0));
    send_voice_event(voice_event(ACT_HALF, REG_DUTY, 8'h00, 1'b0));
    send_voice_event(voice_event(ACT_QUARTER, REG_DUTY, 8'h00, 1'b0));
    send_voice_event(voice_event(ACT_WRITE, REG_DUTY, 8'h00, 1'b1));
    send_voice_event(voice_event(ACT_WRITE, REG_PER_LO, 8'h00, 1'b0));
    send_voice_event(voice_event(ACT_WRITE, REG_PER_HI, 8'h00, 1'b0));
    send_voice_event(voice_event(ACT_TICK, REG_DUTY, 8'hFF, 1'b1));
    send_voice_event(voice_event(ACT_WRITE, REG_SWEEP, 8'h00, 1'b1));
    send_voice_event(voice_event(ACT_HALF, REG_DUTY, 8'h00, 1'b0));
    send_voice_event(voice_event(ACT_ENABLE, REG_DUTY, 8'hFF, 1'b0));
  endtask

  // With the extra subtract on, a zero shift makes the negated target minus
  // one. That must neither mute the voice nor change the period.
  task automatic test_negative_sweep_target();
    set_ones_comp(1'b1);
    send_voice_event(voice_event(ACT_ENABLE, REG_DUTY, 8'h00, 1'b1));
    send_voice_event(voice_event(ACT_WRITE, REG_DUTY, 8'hDF, 1'b0));
    send_voice_event(voice_event(ACT_WRITE, REG_PER_LO, 8'h10, 1'b0));
    send_voice_event(voice_event(ACT_WRITE, REG_PER_HI, 8'h08, 1'b0));
    send_voice_event(voice_event(ACT_WRITE, REG_SWEEP, 8'h88, 1'b0));
    send_voice_event(voice_event(ACT_HALF, REG_DUTY, 8'h00, 1'b0));
    set_ones_comp(1'b0);
  endtask

  // Mostly well-formed programs followed by random events. About one program
  // in ten skips the setup, so the voice also sees writes while it is disabled.
  task automatic test_random_voice_sequences(input int n_events);
    int target;
    int body_len;
    target = voice_events_sent + n_events;
    while (voice_events_sent < target) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) != 0) begin
        send_voice_preamble();
      end
      body_len = $urandom_range(10, 60);
      repeat (body_len) send_voice_event(random_voice_event());
    end
    steady_flow = 1'b0;
  endtask

  // The sink stops for a long stretch while the source keeps offering
  // transactions, so both pipeline stages fill and the input stalls.
  task automatic test_output_backpressure();
    steady_flow   = 1'b1;
    sink_hold_req = 1'b1;
    send_voice_preamble();
    repeat (80) send_voice_event(random_voice_event());
    steady_flow = 1'b0;
  endtask

  // The source goes quiet until every result is back, then starts again.
  task automatic test_sender_drain_pause();
    send_voice_preamble();
    repeat (40) send_voice_event(random_voice_event());
    stop_sending();
    wait_for_drain();
    send_voice_preamble();
    repeat (40) send_voice_event(random_voice_event());
  endtask

  // Predict at each input handshake. Inputs are driven with nonblocking
  // assignments, so the values seen here are the ones the block sampled.
  always @(posedge clk_i) begin : input_capture
    sqv_item_t     item;
    voice_result_t res;
    if (in_valid_i && in_ready_o) begin
      item = {action_i, reg_select_i, write_value_i, enable_bit_i};
      advance_voice(item, res);
      pending_levels.push_back(res);
      action_seen[item.action]++;
    end
  end

  // Each result must match the oldest outstanding prediction.
  always @(posedge clk_i) begin : result_check
    voice_result_t want;
    if (out_valid_o && out_ready_i) begin
      results_checked++;
      if (pending_levels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual level %0d length_active %0b",
                 $time, level_o, length_active_o);
      end else begin
        want = pending_levels.pop_front();
        if (level_o !== want.level) begin
          mismatch_count++;
          $display("%0t: level mismatch, expected %0d, actual %0d",
                   $time, want.level, level_o);
        end
        if (length_active_o !== want.length_active) begin
          mismatch_count++;
          $display("%0t: length_active mismatch, expected %0b, actual %0b",
                   $time, want.length_active, length_active_o);
        end
      end
    end
  end

  // Output sink. It normally stalls at random, runs without stalls while
  // steady_flow is set, and honors a one-off long hold when asked.
  initial begin : output_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
        sink_hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
          stall_left = rand_gap();
        end
      end
    end
  end

  // Ends the run if neither channel completes a transaction for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unused_actions_after_reset();
    test_register_extremes();
    test_negative_sweep_target();
    test_random_voice_sequences(450);
    set_ones_comp(1'b1);
    test_random_voice_sequences(450);
    test_output_backpressure();
    set_ones_comp(1'b0);
    test_sender_drain_pause();

    stop_sending();
    wait_for_drain();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d writes, %0d enables, %0d ticks, %0d quarter and %0d half",
             results_checked, action_seen[ACT_WRITE], action_seen[ACT_ENABLE],
             action_seen[ACT_TICK], action_seen[ACT_QUARTER], action_seen[ACT_HALF]);
    $display("frames, %0d unused codes; both sweep negation modes, a long stall and a drain.",
             action_seen[ACT_UNUSED_LO] + action_seen[ACT_UNUSED_MID] +
             action_seen[ACT_UNUSED_HI]);
    if (mismatch_count == 0 && pending_levels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
